>>> sv/text_console_with_scroll_defines.svh
// Assertion macros shared by the text console RTL.
// Users must have i_clk and an active-low synchronous reset i_rst_n in scope.
`ifndef TEXT_CONSOLE_WITH_SCROLL_DEFINES_SVH
`define TEXT_CONSOLE_WITH_SCROLL_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define TCON_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("text console invariant violated");

// A consequent that must hold in the same cycle as its antecedent.
`define TCON_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("text console implication violated");

`endif

>>> sv/tcon_pkg.sv
// Shared constants, types and action codes of the text console.
// No dependencies; every module refers to it by scoped names.
`timescale 1ns / 1ps

package tcon_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_TOTAL = COLUMNS * ROWS;

    localparam int IDX_W     = 11;
    localparam int CUR_W     = 11;
    localparam int CHAR_W    = 8;
    localparam int ATTR_W    = 8;
    localparam int CELL_W    = CHAR_W + ATTR_W;
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int ROW_W     = $clog2(ROWS);
    localparam int CURROW_W  = $clog2(ROWS + 1);
    localparam int ADDR_W    = $clog2(CELL_TOTAL);

    // Reciprocal of the column count, used to split a cell number into row and column.
    localparam int SPLIT_SHIFT = IDX_W + 1;
    localparam int SPLIT_RECIP = (1 << SPLIT_SHIFT) / COLUMNS;

    localparam logic [1:0] ACT_PUT   = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_NONE    = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;

    typedef struct packed {
        logic             in_range;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_split_res;

endpackage

>>> sv/tcon_cell_ram.sv
// Screen cell store: one write port and one read port with registered read data.
// Depends on tcon_pkg for the depth and cell width.
`timescale 1ns / 1ps

module tcon_cell_ram (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [tcon_pkg::ADDR_W-1:0]  i_waddr,
    input  logic [tcon_pkg::CELL_W-1:0]  i_wdata,
    input  logic                         i_re,
    input  logic [tcon_pkg::ADDR_W-1:0]  i_raddr,
    output logic [tcon_pkg::CELL_W-1:0]  o_rdata
);

    logic [tcon_pkg::CELL_W-1:0] r_mem [tcon_pkg::CELL_TOTAL];
    logic [tcon_pkg::CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/tcon_idx_split.sv
// Two-stage splitter of a cell number into row and column by reciprocal multiply.
// Depends on tcon_pkg for the geometry and the result struct.
`timescale 1ns / 1ps

module tcon_idx_split (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tcon_pkg::IDX_W-1:0]  i_idx,
    output logic                        o_done,
    output tcon_pkg::t_split_res        o_res
);

    localparam int PROD_W = tcon_pkg::IDX_W + tcon_pkg::SPLIT_SHIFT;

    logic                        r_s1_valid;
    logic                        r_s2_valid;
    logic [tcon_pkg::IDX_W-1:0]  r_idx;
    logic [tcon_pkg::IDX_W-1:0]  r_q_est;
    tcon_pkg::t_split_res        r_res;

    logic [PROD_W-1:0]           w_prod;
    logic [tcon_pkg::IDX_W-1:0]  w_rem;
    logic [tcon_pkg::IDX_W-1:0]  w_q;
    logic [tcon_pkg::IDX_W-1:0]  w_col;

    // The estimate is never more than one below the true quotient.
    assign w_prod = PROD_W'(i_idx) * PROD_W'(tcon_pkg::SPLIT_RECIP);
    assign w_rem  = r_idx - tcon_pkg::IDX_W'(int'(r_q_est) * tcon_pkg::COLUMNS);

    always_comb begin
        if (w_rem >= tcon_pkg::IDX_W'(tcon_pkg::COLUMNS)) begin
            w_q   = r_q_est + tcon_pkg::IDX_W'(1);
            w_col = w_rem - tcon_pkg::IDX_W'(tcon_pkg::COLUMNS);
        end else begin
            w_q   = r_q_est;
            w_col = w_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_start;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_idx   <= i_idx;
            r_q_est <= w_prod[PROD_W-1 -: tcon_pkg::IDX_W];
        end
        if (r_s1_valid) begin
            r_res.in_range <= (r_idx < tcon_pkg::IDX_W'(tcon_pkg::CELL_TOTAL));
            r_res.row      <= w_q[tcon_pkg::ROW_W-1:0];
            r_res.col      <= w_col[tcon_pkg::COL_W-1:0];
        end
    end

    assign o_done = r_s2_valid;
    assign o_res  = r_res;

endmodule

>>> sv/text_console_with_scroll.sv
// Text console top level: sequencer, row ring pointer, row valid bits, result register.
// Uses tcon_pkg, tcon_cell_ram, tcon_idx_split and text_console_with_scroll_defines.svh.
// Items end in S_DONE: a printable put via S_PUT, S_MAP, S_CHECK, S_WRITE; a read via S_SPLIT,
// S_MAP, S_CHECK, S_RDREQ, S_RDATA (cut short on a blank row or past the screen); a newline via
// S_PUT; clear and ignored items at once. S_SWEEP first zero fills a row unwritten since reset,
// clear or scroll; stalls hold S_DONE. One item in work; reset is synchronous, no clear pass.
`timescale 1ns / 1ps
`include "text_console_with_scroll_defines.svh"

module text_console_with_scroll (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_action,
    input  logic [tcon_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [tcon_pkg::ATTR_W-1:0]   i_attr,
    input  logic [tcon_pkg::IDX_W-1:0]    i_cell_index,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tcon_pkg::CHAR_W-1:0]   o_cell_char,
    output logic [tcon_pkg::ATTR_W-1:0]   o_cell_attr,
    output logic [tcon_pkg::CUR_W-1:0]    o_cursor_cell,
    output logic                          o_scrolled
);

    // The screen is a ring of physical rows. r_top_row is the physical row that
    // shows as the top line, so a scroll is a pointer bump plus invalidating the
    // row that comes around as the new bottom line. A row whose valid bit is low
    // reads as blank; the first put into such a row zero fills it before writing.
    // All row valid bits clear at once on reset and on a clear beat.

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUT,
        S_SPLIT,
        S_MAP,
        S_CHECK,
        S_SWEEP,
        S_WRITE,
        S_RDREQ,
        S_RDATA,
        S_DONE
    } t_state;

    t_state                             r_state;
    logic                               r_is_read;
    logic [tcon_pkg::CHAR_W-1:0]        r_char;
    logic [tcon_pkg::ATTR_W-1:0]        r_attr;

    // Cursor kept both as row and column and as a linear cell number.
    logic [tcon_pkg::CURROW_W-1:0]      r_cur_row;
    logic [tcon_pkg::COL_W-1:0]         r_cur_col;
    logic [tcon_pkg::CUR_W-1:0]         r_cursor;

    logic [tcon_pkg::ROW_W-1:0]         r_top_row;
    logic [tcon_pkg::ROWS-1:0]          r_row_valid;

    logic [tcon_pkg::ROW_W-1:0]         r_wk_row;
    logic [tcon_pkg::COL_W-1:0]         r_wk_col;
    logic [tcon_pkg::ROW_W-1:0]         r_phys_row;
    logic [tcon_pkg::ADDR_W-1:0]        r_row_base;
    logic [tcon_pkg::COL_W-1:0]         r_sweep_col;

    logic [tcon_pkg::CHAR_W-1:0]        r_res_char;
    logic [tcon_pkg::ATTR_W-1:0]        r_res_attr;
    logic                               r_res_scrolled;

    logic                               r_out_valid;
    logic [tcon_pkg::CHAR_W-1:0]        r_out_char;
    logic [tcon_pkg::ATTR_W-1:0]        r_out_attr;
    logic [tcon_pkg::CUR_W-1:0]         r_out_cursor;
    logic                               r_out_scrolled;

    logic                               w_in_beat;
    logic                               w_at_end;
    logic [tcon_pkg::ROW_W-1:0]         w_row_adj;
    logic [tcon_pkg::COL_W-1:0]         w_col_adj;
    logic [tcon_pkg::CUR_W-1:0]         w_cursor_adj;
    logic [tcon_pkg::ROW_W-1:0]         n_top_row;
    logic [tcon_pkg::ROW_W:0]           w_row_sum;
    logic [tcon_pkg::ROW_W-1:0]         w_phys_row;

    logic                               w_split_done;
    tcon_pkg::t_split_res               w_split_res;

    logic                               w_mem_we;
    logic                               w_mem_re;
    logic [tcon_pkg::ADDR_W-1:0]        w_mem_addr;
    logic [tcon_pkg::CELL_W-1:0]        w_mem_wdata;
    logic [tcon_pkg::CELL_W-1:0]        w_mem_rdata;

    // The input side is open whenever the sequencer is idle, even while a
    // finished result still sits in the output register.
    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_beat  = i_in_valid && !o_in_stall;

    // A cursor one past the last cell means a scroll is pending. Any nonzero put
    // first applies it, which places the cursor at column 0 of the bottom row.
    assign w_at_end     = (r_cur_row == tcon_pkg::CURROW_W'(tcon_pkg::ROWS));
    assign w_row_adj    = w_at_end ? tcon_pkg::ROW_W'(tcon_pkg::ROWS - 1)
                                   : r_cur_row[tcon_pkg::ROW_W-1:0];
    assign w_col_adj    = w_at_end ? '0 : r_cur_col;
    assign w_cursor_adj = w_at_end ? tcon_pkg::CUR_W'(tcon_pkg::CELL_TOTAL - tcon_pkg::COLUMNS)
                                   : r_cursor;
    assign n_top_row    = (r_top_row == tcon_pkg::ROW_W'(tcon_pkg::ROWS - 1))
                          ? '0 : r_top_row + tcon_pkg::ROW_W'(1);

    // Logical row to physical row: one add and one conditional subtract.
    assign w_row_sum  = {1'b0, r_top_row} + {1'b0, r_wk_row};
    assign w_phys_row = (w_row_sum >= (tcon_pkg::ROW_W + 1)'(tcon_pkg::ROWS))
                        ? tcon_pkg::ROW_W'(w_row_sum - (tcon_pkg::ROW_W + 1)'(tcon_pkg::ROWS))
                        : w_row_sum[tcon_pkg::ROW_W-1:0];

    assign w_mem_we    = (r_state == S_SWEEP) || (r_state == S_WRITE);
    assign w_mem_re    = (r_state == S_RDREQ);
    assign w_mem_addr  = r_row_base + tcon_pkg::ADDR_W'((r_state == S_SWEEP) ? r_sweep_col
                                                                              : r_wk_col);
    assign w_mem_wdata = (r_state == S_SWEEP) ? '0 : {r_attr, r_char};

    tcon_idx_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_in_beat && (i_action == tcon_pkg::ACT_READ)),
        .i_idx   (i_cell_index),
        .o_done  (w_split_done),
        .o_res   (w_split_res)
    );

    tcon_cell_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_addr),
        .o_rdata (w_mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur_row   <= '0;
            r_cur_col   <= '0;
            r_cursor    <= '0;
            r_top_row   <= '0;
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // In S_DONE the hand-off below decides the output valid on its own.
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_beat) begin
                        r_char         <= i_char_code;
                        r_attr         <= i_attr;
                        r_is_read      <= (i_action == tcon_pkg::ACT_READ);
                        r_res_char     <= '0;
                        r_res_attr     <= '0;
                        r_res_scrolled <= 1'b0;
                        if (i_action == tcon_pkg::ACT_PUT) begin
                            r_state <= (i_char_code == tcon_pkg::CHAR_NONE) ? S_DONE : S_PUT;
                        end else if (i_action == tcon_pkg::ACT_READ) begin
                            r_state   <= S_SPLIT;
                        end else if (i_action == tcon_pkg::ACT_CLEAR) begin
                            // Every row reads blank again; rows are refilled on first use.
                            r_row_valid <= '0;
                            r_cur_row   <= '0;
                            r_cur_col   <= '0;
                            r_cursor    <= '0;
                            r_state     <= S_DONE;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end

                S_PUT: begin
                    if (w_at_end) begin
                        // Scroll: the old top row comes around as the blank bottom row.
                        r_top_row              <= n_top_row;
                        r_row_valid[r_top_row] <= 1'b0;
                        r_res_scrolled         <= 1'b1;
                    end
                    if (r_char == tcon_pkg::CHAR_NEWLINE) begin
                        r_cur_row <= tcon_pkg::CURROW_W'(w_row_adj) + tcon_pkg::CURROW_W'(1);
                        r_cur_col <= '0;
                        r_cursor  <= w_cursor_adj - tcon_pkg::CUR_W'(w_col_adj)
                                     + tcon_pkg::CUR_W'(tcon_pkg::COLUMNS);
                        r_state   <= S_DONE;
                    end else begin
                        r_cur_row <= tcon_pkg::CURROW_W'(w_row_adj);
                        r_cur_col <= w_col_adj;
                        r_cursor  <= w_cursor_adj;
                        r_wk_row  <= w_row_adj;
                        r_wk_col  <= w_col_adj;
                        r_state   <= S_MAP;
                    end
                end

                S_SPLIT: begin
                    if (w_split_done) begin
                        r_wk_row <= w_split_res.row;
                        r_wk_col <= w_split_res.col;
                        // A cell number past the screen reads as a blank cell.
                        r_state  <= w_split_res.in_range ? S_MAP : S_DONE;
                    end
                end

                S_MAP: begin
                    r_phys_row <= w_phys_row;
                    r_state    <= S_CHECK;
                end

                S_CHECK: begin
                    r_row_base  <= tcon_pkg::ADDR_W'(int'(r_phys_row) * tcon_pkg::COLUMNS);
                    r_sweep_col <= '0;
                    if (r_is_read) begin
                        r_state <= r_row_valid[r_phys_row] ? S_RDREQ : S_DONE;
                    end else begin
                        r_state <= r_row_valid[r_phys_row] ? S_WRITE : S_SWEEP;
                    end
                end

                S_SWEEP: begin
                    if (r_sweep_col == tcon_pkg::COL_W'(tcon_pkg::COLUMNS - 1)) begin
                        r_row_valid[r_phys_row] <= 1'b1;
                        r_state                 <= S_WRITE;
                    end else begin
                        r_sweep_col <= r_sweep_col + tcon_pkg::COL_W'(1);
                    end
                end

                S_WRITE: begin
                    if (r_cur_col == tcon_pkg::COL_W'(tcon_pkg::COLUMNS - 1)) begin
                        r_cur_col <= '0;
                        r_cur_row <= r_cur_row + tcon_pkg::CURROW_W'(1);
                    end else begin
                        r_cur_col <= r_cur_col + tcon_pkg::COL_W'(1);
                    end
                    r_cursor <= r_cursor + tcon_pkg::CUR_W'(1);
                    r_state  <= S_DONE;
                end

                S_RDREQ: begin
                    r_state <= S_RDATA;
                end

                S_RDATA: begin
                    r_res_char <= w_mem_rdata[tcon_pkg::CHAR_W-1:0];
                    r_res_attr <= w_mem_rdata[tcon_pkg::CELL_W-1:tcon_pkg::CHAR_W];
                    r_state    <= S_DONE;
                end

                S_DONE: begin
                    // Hand the result to the output register once it is free.
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid    <= 1'b1;
                        r_out_char     <= r_res_char;
                        r_out_attr     <= r_res_attr;
                        r_out_cursor   <= r_cursor;
                        r_out_scrolled <= r_res_scrolled;
                        r_state        <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_cell_char   = r_out_char;
    assign o_cell_attr   = r_out_attr;
    assign o_cursor_cell = r_out_cursor;
    assign o_scrolled    = r_out_scrolled;

    // The linear cursor and the row and column form must always agree.
    `TCON_ASSERT_ALWAYS(a_cursor_agrees, r_cursor == tcon_pkg::CUR_W'(int'(r_cur_row) * tcon_pkg::COLUMNS + int'(r_cur_col)))
    // A pending scroll always sits at column zero.
    `TCON_ASSERT_IMP(a_end_col_zero, r_cur_row == tcon_pkg::CURROW_W'(tcon_pkg::ROWS), r_cur_col == '0)
    // A character is only written into a row that has been zero filled.
    `TCON_ASSERT_IMP(a_write_row_valid, r_state == S_WRITE, r_row_valid[r_phys_row])
    // A beat that scrolled came from a put and carries no cell contents.
    `TCON_ASSERT_IMP(a_scroll_blank, o_out_valid && o_scrolled, o_cell_char == '0 && o_cell_attr == '0)

endmodule
